// File: rtl/core/cbws_pkg.sv
package cbws_pkg;

    // Sizing of the storage.
    localparam int MAX_LINE    = 2048;
    localparam int MAX_WIN     = 15;
    localparam int SAMPLE_BITS = 16;

    // Widths fixed by the register and result formats.
    localparam int LEN_W     = 12;
    localparam int WIN_W     = 4;
    localparam int ROW_W     = 12;
    localparam int SUM_W     = 24;
    localparam int REG_IDX_W = 2;

    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    // Derived widths.
    localparam int COL_W    = $clog2(MAX_LINE);
    localparam int SLOT_W   = $clog2(MAX_WIN + 1);
    localparam int LS_DEPTH = MAX_WIN * MAX_LINE;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int CS_W     = SAMPLE_BITS + $clog2(MAX_WIN + 1);
    localparam int ACC_W    = SAMPLE_BITS + $clog2(MAX_WIN * MAX_WIN + 1);
    localparam int HIST_D   = MAX_WIN + 1;
    localparam int HIST_AW  = $clog2(HIST_D);
    localparam int FIFO_D   = 4;
    localparam int FIFO_AW  = $clog2(FIFO_D);
    localparam int FIFO_CW  = $clog2(FIFO_D + 2);

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_ROWS   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIN_COLS   = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [WIN_W-1:0] win_rows;
        logic [WIN_W-1:0] win_cols;
    } cbws_cfg_t;

    // Per-sample control passed from the line store stage to the summing stage.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             sub_en;
        logic             emit;
        logic             last;
    } cbws_ctl_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_re;
        logic signed [SUM_W-1:0] sum_im;
        logic                    row_end;
    } cbws_res_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0)
            r = LEN_W'(1);
        else if (int'(v) > MAX_LINE)
            r = LEN_W'(MAX_LINE);
        return r;
    endfunction

    function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] r;
        r = v;
        if (v == '0)
            r = WIN_W'(1);
        else if (int'(v) > MAX_WIN)
            r = WIN_W'(MAX_WIN);
        return r;
    endfunction

    function automatic logic [LS_AW-1:0] ls_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [COL_W-1:0] col);
        logic [LS_AW-1:0] a;
        a = LS_AW'(slot) * LS_AW'(MAX_LINE) + LS_AW'(col);
        return a;
    endfunction

endpackage

// File: rtl/core/cbws_in_if.sv
interface cbws_in_if;
    import cbws_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic                          frame_start;

    modport source (output valid, output sample_re, output sample_im,
                     output frame_start, input ready);
    modport sink (input valid, input sample_re, input sample_im,
                  input frame_start, output ready);
endinterface

// File: rtl/core/cbws_out_if.sv
interface cbws_out_if;
    import cbws_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic                    row_end;

    modport source (output valid, output sum_re, output sum_im,
                     output row_end, input ready);
    modport sink (input valid, input sum_re, input sum_im,
                  input row_end, output ready);
endinterface

// File: rtl/core/cbws_line_store.sv
module cbws_line_store (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cbws_pkg::cbws_cfg_t                    cfg,
    input  logic                                   restart,
    input  logic                                   fire,
    input  logic signed [cbws_pkg::SAMPLE_BITS-1:0] sample_re,
    input  logic signed [cbws_pkg::SAMPLE_BITS-1:0] sample_im,
    input  logic                                   frame_start,
    output logic [cbws_pkg::COL_W-1:0]             rd_col,
    output logic                                   b_valid,
    output cbws_pkg::cbws_ctl_t                    ctl,
    output logic signed [cbws_pkg::SAMPLE_BITS-1:0] new_re,
    output logic signed [cbws_pkg::SAMPLE_BITS-1:0] new_im,
    output logic signed [cbws_pkg::SAMPLE_BITS-1:0] old_re,
    output logic signed [cbws_pkg::SAMPLE_BITS-1:0] old_im
);
    import cbws_pkg::*;

    logic [COL_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     b_valid_reg;
    cbws_ctl_t                ctl_reg;
    logic [2*SAMPLE_BITS-1:0] ls_q_reg;

    logic [COL_W-1:0]   col_a;
    logic [ROW_W-1:0]   row_a;
    logic               last_a;
    logic [SLOT_W:0]    sub_slot_sum;
    logic [SLOT_W-1:0]  sub_slot;
    logic [LS_AW-1:0]   rd_addr;
    logic [LS_AW-1:0]   wr_addr;
    cbws_ctl_t          ctl_a;

    logic [2*SAMPLE_BITS-1:0] ls_mem [0:LS_DEPTH-1];

    always_comb
    begin
        col_a = frame_start ? '0 : col_reg;
        if (LEN_W'(col_a) >= cfg.len)
            col_a = '0;
        row_a  = frame_start ? '0 : row_reg;
        last_a = (LEN_W'(col_a) + LEN_W'(1)) == cfg.len;

        // Ring slot that holds the row leaving the column sums.
        sub_slot_sum = {1'b0, slot_reg} + (SLOT_W + 1)'(MAX_WIN)
                       - (SLOT_W + 1)'(cfg.win_rows);
        if (sub_slot_sum >= (SLOT_W + 1)'(MAX_WIN))
            sub_slot_sum = sub_slot_sum - (SLOT_W + 1)'(MAX_WIN);
        sub_slot = sub_slot_sum[SLOT_W-1:0];

        rd_addr = ls_addr(sub_slot, col_a);
        wr_addr = ls_addr(slot_reg, col_a);

        ctl_a.col       = col_a;
        ctl_a.first_row = (row_a == '0);
        ctl_a.sub_en    = row_a >= ROW_W'(cfg.win_rows);
        ctl_a.emit      = (row_a >= ROW_W'(cfg.win_rows - WIN_W'(1)))
                          && (col_a >= COL_W'(cfg.win_cols - WIN_W'(1)));
        ctl_a.last      = last_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= fire;
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (fire)
            begin
                if (last_a)
                begin
                    col_reg  <= '0;
                    row_reg  <= (row_a == ROW_MAX) ? row_a : row_a + ROW_W'(1);
                    slot_reg <= (slot_reg == SLOT_W'(MAX_WIN - 1)) ? '0
                                : slot_reg + SLOT_W'(1);
                end
                else
                begin
                    col_reg <= col_a + COL_W'(1);
                    row_reg <= row_a;
                end
            end
        end
    end

    // The read sees the old entry when it hits the address being written,
    // which is the case for a window as tall as the ring.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ls_q_reg         <= ls_mem[rd_addr];
            ls_mem[wr_addr]  <= {sample_re, sample_im};
            ctl_reg          <= ctl_a;
            new_re           <= sample_re;
            new_im           <= sample_im;
        end
    end

    assign rd_col  = col_a;
    assign b_valid = b_valid_reg;
    assign ctl     = ctl_reg;
    assign old_re  = $signed(ls_q_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign old_im  = $signed(ls_q_reg[SAMPLE_BITS-1:0]);

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < SLOT_W'(MAX_WIN))
        else $error("line slot left the ring");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(col_reg) < cfg.len)
        else $error("column position beyond row length");

endmodule

// File: rtl/core/cbws_column_sum.sv
module cbws_column_sum (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    rd_fire,
    input  logic [cbws_pkg::COL_W-1:0]              rd_col,
    input  logic                                    b_valid,
    input  cbws_pkg::cbws_ctl_t                     ctl,
    input  logic signed [cbws_pkg::SAMPLE_BITS-1:0] new_re,
    input  logic signed [cbws_pkg::SAMPLE_BITS-1:0] new_im,
    input  logic signed [cbws_pkg::SAMPLE_BITS-1:0] old_re,
    input  logic signed [cbws_pkg::SAMPLE_BITS-1:0] old_im,
    input  logic [cbws_pkg::WIN_W-1:0]              win_cols,
    output logic                                    res_valid,
    output cbws_pkg::cbws_res_t                     res
);
    import cbws_pkg::*;

    logic [2*CS_W-1:0]       cs_q_reg;
    logic                    fwd_reg;
    logic signed [CS_W-1:0]  fwd_re_reg;
    logic signed [CS_W-1:0]  fwd_im_reg;
    logic signed [CS_W-1:0]  hist_re_reg [0:HIST_D-1];
    logic signed [CS_W-1:0]  hist_im_reg [0:HIST_D-1];
    logic signed [ACC_W-1:0] win_re_reg;
    logic signed [ACC_W-1:0] win_im_reg;

    logic signed [CS_W-1:0]  prev_re;
    logic signed [CS_W-1:0]  prev_im;
    logic signed [CS_W-1:0]  cs_re_next;
    logic signed [CS_W-1:0]  cs_im_next;
    logic [HIST_AW-1:0]      tap;
    logic                    win_sub;
    logic signed [ACC_W-1:0] win_re_next;
    logic signed [ACC_W-1:0] win_im_next;

    logic [2*CS_W-1:0] cs_mem [0:MAX_LINE-1];

    always_comb
    begin
        // Column sum read, with the previous result taken when it wrote the
        // same column in the cycle of the read.
        if (ctl.first_row)
        begin
            prev_re = '0;
            prev_im = '0;
        end
        else if (fwd_reg)
        begin
            prev_re = fwd_re_reg;
            prev_im = fwd_im_reg;
        end
        else
        begin
            prev_re = $signed(cs_q_reg[2*CS_W-1:CS_W]);
            prev_im = $signed(cs_q_reg[CS_W-1:0]);
        end
        cs_re_next = prev_re + CS_W'(new_re) - (ctl.sub_en ? CS_W'(old_re) : CS_W'(0));
        cs_im_next = prev_im + CS_W'(new_im) - (ctl.sub_en ? CS_W'(old_im) : CS_W'(0));

        tap     = HIST_AW'(win_cols - WIN_W'(1));
        win_sub = ctl.col >= COL_W'(win_cols);
        win_re_next = ((ctl.col == '0) ? ACC_W'(0) : win_re_reg) + ACC_W'(cs_re_next)
                      - (win_sub ? ACC_W'(hist_re_reg[tap]) : ACC_W'(0));
        win_im_next = ((ctl.col == '0) ? ACC_W'(0) : win_im_reg) + ACC_W'(cs_im_next)
                      - (win_sub ? ACC_W'(hist_im_reg[tap]) : ACC_W'(0));
    end

    always_ff @(posedge clk)
    begin
        if (rd_fire)
            cs_q_reg <= cs_mem[rd_col];
        if (b_valid)
        begin
            cs_mem[ctl.col] <= {cs_re_next, cs_im_next};
            fwd_re_reg      <= cs_re_next;
            fwd_im_reg      <= cs_im_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg    <= 1'b0;
            win_re_reg <= '0;
            win_im_reg <= '0;
            for (int i = 0; i < HIST_D; i++)
            begin
                hist_re_reg[i] <= '0;
                hist_im_reg[i] <= '0;
            end
        end
        else
        begin
            fwd_reg <= rd_fire && b_valid && (rd_col == ctl.col);
            if (b_valid)
            begin
                win_re_reg     <= win_re_next;
                win_im_reg     <= win_im_next;
                hist_re_reg[0] <= cs_re_next;
                hist_im_reg[0] <= cs_im_next;
                for (int i = 1; i < HIST_D; i++)
                begin
                    hist_re_reg[i] <= hist_re_reg[i-1];
                    hist_im_reg[i] <= hist_im_reg[i-1];
                end
            end
        end
    end

    assign res_valid   = b_valid && ctl.emit;
    assign res.sum_re  = SUM_W'(win_re_next);
    assign res.sum_im  = SUM_W'(win_im_next);
    assign res.row_end = ctl.last;

    a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> b_valid && (ctl.col == $past(ctl.col)))
        else $error("column sum forwarded across different columns");

endmodule

// File: rtl/core/cbws_out_fifo.sv
module cbws_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cbws_pkg::cbws_res_t push_data,
    input  logic                pending,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output cbws_pkg::cbws_res_t out_data
);
    import cbws_pkg::*;

    cbws_res_t          mem_reg [0:FIFO_D-1];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];
    // A new transaction may enter only if its result and the one in flight fit.
    assign room      = (count_reg + FIFO_CW'(pending)) < FIFO_CW'(FIFO_D);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            count_reg <= count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < FIFO_CW'(FIFO_D)) || pop)
        else $error("result queue overflow");

endmodule

// File: rtl/core/complex_boxcar_window_sum.sv
// Channel   Role     Payload                               Transaction when
// samples   sink     sample_re, sample_im, frame_start     valid && ready
// sums      source   sum_re, sum_im, row_end               valid && ready
// config    write    wr_en, reg_index, wr_data             wr_en high
//
// One sample is accepted per cycle while the output queue has room.
// The rate is set by the single read port of each memory: line store and column sums.
// Reset clears positions, the window sum and the column sum history; no memory is cleared.
// The output queue holds four sums. The sample side keeps streaming through short
// output stalls and stops once the queued sums plus the transaction in the summing
// stage would fill the queue.
module complex_boxcar_window_sum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cbws_in_if.sink                              samples,
    cbws_out_if.source                           sums,
    input  logic                                 wr_en,
    input  logic [cbws_pkg::REG_IDX_W-1:0]       reg_index,
    input  logic [cbws_pkg::LEN_W-1:0]           wr_data
);
    import cbws_pkg::*;

    // Configuration is held already clamped to its legal range, so the datapath
    // never sees a zero length or an oversized window.
    cbws_cfg_t cfg_reg;
    logic      restart;
    logic      fire;
    logic      room;
    logic      b_valid;
    logic      res_valid;
    cbws_ctl_t ctl;
    cbws_res_t res;
    cbws_res_t head;
    logic [COL_W-1:0]              rd_col;
    logic signed [SAMPLE_BITS-1:0] new_re;
    logic signed [SAMPLE_BITS-1:0] new_im;
    logic signed [SAMPLE_BITS-1:0] old_re;
    logic signed [SAMPLE_BITS-1:0] old_im;

    // Any write to a defined register starts a new frame.
    assign restart = wr_en && ((reg_index == REG_ROW_LENGTH)
                               || (reg_index == REG_WIN_ROWS)
                               || (reg_index == REG_WIN_COLS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.len      <= LEN_W'(MAX_LINE);
            cfg_reg.win_rows <= WIN_W'(3);
            cfg_reg.win_cols <= WIN_W'(3);
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_ROW_LENGTH: cfg_reg.len      <= clamp_len(wr_data);
                REG_WIN_ROWS:   cfg_reg.win_rows <= clamp_win(wr_data[WIN_W-1:0]);
                REG_WIN_COLS:   cfg_reg.win_cols <= clamp_win(wr_data[WIN_W-1:0]);
                default:        ;
            endcase
        end
    end

    // Handshake: ready uses only queue room and the summing stage, never the output side.
    assign samples.ready = room;
    assign fire          = samples.valid && room;

    // First stage: position tracking, line store write and read of the sample
    // that falls out of the column sums.
    cbws_line_store u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .restart    (restart),
        .fire       (fire),
        .sample_re  (samples.sample_re),
        .sample_im  (samples.sample_im),
        .frame_start(samples.frame_start),
        .rd_col     (rd_col),
        .b_valid    (b_valid),
        .ctl        (ctl),
        .new_re     (new_re),
        .new_im     (new_im),
        .old_re     (old_re),
        .old_im     (old_im)
    );

    // Second stage: column sum update in its memory and the running sum across
    // the window columns.
    cbws_column_sum u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_fire  (fire),
        .rd_col   (rd_col),
        .b_valid  (b_valid),
        .ctl      (ctl),
        .new_re   (new_re),
        .new_im   (new_im),
        .old_re   (old_re),
        .old_im   (old_im),
        .win_cols (cfg_reg.win_cols),
        .res_valid(res_valid),
        .res      (res)
    );

    cbws_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .push_data(res),
        .pending  (b_valid),
        .room     (room),
        .out_valid(sums.valid),
        .out_ready(sums.ready),
        .out_data (head)
    );

    assign sums.sum_re  = head.sum_re;
    assign sums.sum_im  = head.sum_im;
    assign sums.row_end = head.row_end;

    a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> b_valid)
        else $error("accepted transaction did not reach the summing stage");

endmodule
